[src/assert_macros.svh]
// Assertion macros used by the checker file of the move planner.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked property that is checked during reset as well.
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/cxymp_pkg.sv]
// Shared widths, register codes, configuration and result types of the
// CoreXY move planner. No dependencies.
`default_nettype none

package cxymp_pkg;

  localparam int COORD_W   = 20;
  localparam int SCALE_W   = 16;
  localparam int PERIOD_W  = 16;
  localparam int STEP_W    = 20;
  localparam int COUNT_W   = 21;
  localparam int SEED_W    = 20;
  localparam int ACCEL_W   = 11;
  localparam int RAMP_W    = 19;
  localparam int PROD_W    = COORD_W + SCALE_W;
  localparam int ADDR_W    = 5;
  localparam int APB_W     = 32;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 136;

  // Upper bound of the acceleration ramp in master steps.
  localparam logic [RAMP_W-1:0] RAMP_CAP = 19'd1200;

  typedef enum logic [2:0] {
    REG_CLAMP_MIN      = 3'd0,
    REG_CLAMP_MAX_X    = 3'd1,
    REG_CLAMP_MAX_Y    = 3'd2,
    REG_STEP_SCALE     = 3'd3,
    REG_TRAVEL_PERIOD  = 3'd4,
    REG_DRAWING_PERIOD = 3'd5,
    REG_START_PERIOD   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0]  clamp_min;
    logic [COORD_W-1:0]  clamp_max_x;
    logic [COORD_W-1:0]  clamp_max_y;
    logic [SCALE_W-1:0]  step_scale;
    logic [PERIOD_W-1:0] travel_period;
    logic [PERIOD_W-1:0] drawing_period;
    logic [PERIOD_W-1:0] start_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    clamp_min:      20'd0,
    clamp_max_x:    20'd51200,
    clamp_max_y:    20'd51200,
    step_scale:     16'd20480,
    travel_period:  16'd200,
    drawing_period: 16'd400,
    start_period:   16'd1000
  };

  typedef struct packed {
    logic [COUNT_W-1:0]  decel_start;
    logic [ACCEL_W-1:0]  accel_len;
    logic [PERIOD_W-1:0] ramp_start_period;
    logic [PERIOD_W-1:0] cruise_period;
    logic                pen_change;
    logic                pen_state;
    logic [SEED_W-1:0]   error_seed;
    logic [COUNT_W-1:0]  minor_steps;
    logic [COUNT_W-1:0]  major_steps;
    logic                a_is_master;
    logic                dir_b;
    logic                dir_a;
  } move_t;

endpackage

`default_nettype wire

[src/cxymp_regs.sv]
// Configuration register file with its APB-style write and read port.
// Depends on cxymp_pkg.
`default_nettype none

module cxymp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cxymp_pkg::ADDR_W-1:0]  paddr,
  input  logic [cxymp_pkg::APB_W-1:0]   pwdata,
  output logic [cxymp_pkg::APB_W-1:0]   prdata,
  output cxymp_pkg::cfg_t               cfg
);
  import cxymp_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_CLAMP_MIN:      cfg.clamp_min      <= pwdata[COORD_W-1:0];
        REG_CLAMP_MAX_X:    cfg.clamp_max_x    <= pwdata[COORD_W-1:0];
        REG_CLAMP_MAX_Y:    cfg.clamp_max_y    <= pwdata[COORD_W-1:0];
        REG_STEP_SCALE:     cfg.step_scale     <= pwdata[SCALE_W-1:0];
        REG_TRAVEL_PERIOD:  cfg.travel_period  <= pwdata[PERIOD_W-1:0];
        REG_DRAWING_PERIOD: cfg.drawing_period <= pwdata[PERIOD_W-1:0];
        REG_START_PERIOD:   cfg.start_period   <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_CLAMP_MIN:      prdata = {{(APB_W-COORD_W){1'b0}}, cfg.clamp_min};
      REG_CLAMP_MAX_X:    prdata = {{(APB_W-COORD_W){1'b0}}, cfg.clamp_max_x};
      REG_CLAMP_MAX_Y:    prdata = {{(APB_W-COORD_W){1'b0}}, cfg.clamp_max_y};
      REG_STEP_SCALE:     prdata = {{(APB_W-SCALE_W){1'b0}}, cfg.step_scale};
      REG_TRAVEL_PERIOD:  prdata = {{(APB_W-PERIOD_W){1'b0}}, cfg.travel_period};
      REG_DRAWING_PERIOD: prdata = {{(APB_W-PERIOD_W){1'b0}}, cfg.drawing_period};
      REG_START_PERIOD:   prdata = {{(APB_W-PERIOD_W){1'b0}}, cfg.start_period};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/cxymp_scale.sv]
// Clamp stage: limits both coordinates to the window and converts them to
// motor steps with one multiplier per axis. Depends on cxymp_pkg.
`default_nettype none

module cxymp_scale (
  input  logic                          clk,
  input  logic                          load,
  input  logic [cxymp_pkg::COORD_W-1:0] target_x,
  input  logic [cxymp_pkg::COORD_W-1:0] target_y,
  input  logic                          pen_up,
  input  cxymp_pkg::cfg_t               cfg,
  output logic [cxymp_pkg::STEP_W-1:0]  step_x,
  output logic [cxymp_pkg::STEP_W-1:0]  step_y,
  output logic                          pen_q
);
  import cxymp_pkg::*;

  logic [COORD_W-1:0] lo_x, lo_y, cx, cy;
  logic [PROD_W-1:0]  prod_x, prod_y;

  always_comb begin
    // Lower bound first, then upper, so the upper bound wins if they cross.
    lo_x = (target_x < cfg.clamp_min) ? cfg.clamp_min : target_x;
    lo_y = (target_y < cfg.clamp_min) ? cfg.clamp_min : target_y;
    cx   = (lo_x > cfg.clamp_max_x) ? cfg.clamp_max_x : lo_x;
    cy   = (lo_y > cfg.clamp_max_y) ? cfg.clamp_max_y : lo_y;
    prod_x = {{SCALE_W{1'b0}}, cx} * {{COORD_W{1'b0}}, cfg.step_scale};
    prod_y = {{SCALE_W{1'b0}}, cy} * {{COORD_W{1'b0}}, cfg.step_scale};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      step_x <= prod_x[PROD_W-1:PROD_W-STEP_W];
      step_y <= prod_y[PROD_W-1:PROD_W-STEP_W];
      pen_q  <= pen_up;
    end
  end

endmodule

`default_nettype wire

[src/cxymp_move.sv]
// Move stage: holds the step position and pen state, forms the CoreXY
// deltas and builds the registered move descriptor. Depends on cxymp_pkg.
`default_nettype none

module cxymp_move (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [cxymp_pkg::STEP_W-1:0] step_x,
  input  logic [cxymp_pkg::STEP_W-1:0] step_y,
  input  logic                         pen,
  input  cxymp_pkg::cfg_t              cfg,
  output cxymp_pkg::move_t             res
);
  import cxymp_pkg::*;

  logic [STEP_W-1:0]  pos_x, pos_y;
  logic               pen_now;

  logic [STEP_W:0]    dx, dy;
  logic [STEP_W+1:0]  a, b, neg_a, neg_b;
  logic [COUNT_W-1:0] abs_a, abs_b, major, minor;
  logic [RAMP_W-1:0]  ramp;
  logic               a_master;
  move_t              res_next;

  always_comb begin
    dx    = {1'b0, step_x} - {1'b0, pos_x};
    dy    = {1'b0, step_y} - {1'b0, pos_y};
    a     = {dy[STEP_W], dy} + {dx[STEP_W], dx};
    b     = {dy[STEP_W], dy} - {dx[STEP_W], dx};
    neg_a = -a;
    neg_b = -b;
    abs_a = a[STEP_W+1] ? neg_a[COUNT_W-1:0] : a[COUNT_W-1:0];
    abs_b = b[STEP_W+1] ? neg_b[COUNT_W-1:0] : b[COUNT_W-1:0];
    a_master = (abs_a >= abs_b);
    major = a_master ? abs_a : abs_b;
    minor = a_master ? abs_b : abs_a;
    ramp  = (major[COUNT_W-1:2] > RAMP_CAP) ? RAMP_CAP : major[COUNT_W-1:2];

    res_next.dir_a             = a[STEP_W+1];
    res_next.dir_b             = b[STEP_W+1];
    res_next.a_is_master       = a_master;
    res_next.major_steps       = major;
    res_next.minor_steps       = minor;
    res_next.error_seed        = major[COUNT_W-1:1];
    res_next.pen_state         = pen;
    res_next.pen_change        = pen ^ pen_now;
    res_next.cruise_period     = pen ? cfg.travel_period : cfg.drawing_period;
    res_next.ramp_start_period = cfg.start_period;
    res_next.accel_len         = ramp[ACCEL_W-1:0];
    res_next.decel_start       = major - {{(COUNT_W-RAMP_W){1'b0}}, ramp};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      pen_now <= 1'b1;
    end else if (load) begin
      pos_x   <= step_x;
      pos_y   <= step_y;
      pen_now <= pen;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

[src/corexy_move_planner.sv]
// A request accepted at one clock edge lands in the input register at that
// edge, then passes the clamp/scale register and the descriptor register
// before its move descriptor shows on the output. Throughput: one request
// per cycle while the output is not stalled, set by the three-register
// pipeline with the stored step position updated in the last stage. Reset
// (rst, synchronous, active high) empties the pipeline, loads the register
// defaults, zeroes the step position and sets the pen up.
`default_nettype none

module corexy_move_planner (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [19:0] target_x, [39:20] target_y, [40] pen_up, [47:41] zero.
  input  logic [cxymp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] dir_a, [1] dir_b, [2] a_is_master, [23:3] major_steps,
  // [44:24] minor_steps, [64:45] error_seed, [65] pen_state,
  // [66] pen_change, [82:67] cruise_period, [98:83] ramp_start_period,
  // [109:99] accel_len, [130:110] decel_start, [135:131] zero.
  output logic [cxymp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cxymp_pkg::ADDR_W-1:0]      paddr,
  input  logic [cxymp_pkg::APB_W-1:0]       pwdata,
  output logic [cxymp_pkg::APB_W-1:0]       prdata,
  output logic                              pready
);
  import cxymp_pkg::*;

  cfg_t  cfg;
  move_t res;

  // Stage valid flags. Each stage takes a new request when it is empty or
  // when its content moves on in the same cycle, so the pipeline keeps
  // flowing while a finished descriptor waits, as long as a stage is free.
  logic in_valid, scale_valid;
  logic in_ready, scale_ready, out_ready;

  logic [COORD_W-1:0] in_x, in_y;
  logic               in_pen;
  logic [STEP_W-1:0]  step_x, step_y;
  logic               step_pen;

  assign pready = 1'b1;

  assign out_ready   = ~m_axis_tvalid | m_axis_tready;
  assign scale_ready = ~scale_valid | out_ready;
  assign in_ready    = ~in_valid | scale_ready;
  assign s_axis_tready = in_ready;

  cxymp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Input register: holds the raw request.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && in_ready) begin
      in_x   <= s_axis_tdata[COORD_W-1:0];
      in_y   <= s_axis_tdata[2*COORD_W-1:COORD_W];
      in_pen <= s_axis_tdata[2*COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      scale_valid   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid <= s_axis_tvalid;
      end
      if (scale_ready) begin
        scale_valid <= in_valid;
      end
      if (out_ready) begin
        m_axis_tvalid <= scale_valid;
      end
    end
  end

  // Clamp and scale to motor steps.
  cxymp_scale u_scale (
    .clk      (clk),
    .load     (in_valid & scale_ready),
    .target_x (in_x),
    .target_y (in_y),
    .pen_up   (in_pen),
    .cfg      (cfg),
    .step_x   (step_x),
    .step_y   (step_y),
    .pen_q    (step_pen)
  );

  // Deltas, CoreXY mix and descriptor. The stored position advances only
  // when a request enters the descriptor register, which keeps the order
  // of the position updates equal to the order of the requests.
  cxymp_move u_move (
    .clk    (clk),
    .rst    (rst),
    .load   (scale_valid & out_ready),
    .step_x (step_x),
    .step_y (step_y),
    .pen    (step_pen),
    .cfg    (cfg),
    .res    (res)
  );

  assign m_axis_tdata = {5'b0,
                         res.decel_start,
                         res.accel_len,
                         res.ramp_start_period,
                         res.cruise_period,
                         res.pen_change,
                         res.pen_state,
                         res.error_seed,
                         res.minor_steps,
                         res.major_steps,
                         res.a_is_master,
                         res.dir_b,
                         res.dir_a};

endmodule

`default_nettype wire

[src/cxymp_checker.sv]
// Port-level checks of the move planner output stream, bound to the top.
// Depends on cxymp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cxymp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [cxymp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import cxymp_pkg::*;

  logic [COUNT_W-1:0] major, minor, decel;
  logic [SEED_W-1:0]  seed;
  logic [ACCEL_W-1:0] accel;

  assign major = m_axis_tdata[23:3];
  assign minor = m_axis_tdata[44:24];
  assign seed  = m_axis_tdata[64:45];
  assign accel = m_axis_tdata[109:99];
  assign decel = m_axis_tdata[130:110];

  `ASSERT_CLK(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output request dropped while stalled")
  `ASSERT_CLK_NORST(a_reset_empty, clk, rst |=> !m_axis_tvalid, "output valid after reset")
  `ASSERT_CLK(a_major_minor, clk, rst, m_axis_tvalid |-> (major >= minor) && (seed == major[COUNT_W-1:1]), "major/minor or seed inconsistent")
  `ASSERT_CLK(a_ramp, clk, rst, m_axis_tvalid |-> (accel <= RAMP_CAP[ACCEL_W-1:0]) && (({10'b0, accel} + decel) == major), "ramp bounds inconsistent")

endmodule

bind corexy_move_planner cxymp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
